>>> design/pcc_pkg.sv
package pcc_pkg;

  // datapath widths
  localparam int DATA_W = 35;
  localparam int Z_W    = 32;
  localparam int GAIN_W = 30;
  localparam int ATAN_W = 29;
  localparam int GUARD  = 16;

  // angle limits in 1/128 degree
  localparam int HALF_TURN    = 23040;
  localparam int FULL_TURN    = 46080;
  localparam int QUARTER_TURN = 11520;

  // gain compensation constant pieces, Q30
  localparam longint K_BASE = 64'd652032874;
  localparam longint K_TAIL = 64'd434688583;

  // atan(2^-i) in units of 2^-23 degree
  localparam logic [ATAN_W-1:0] ATAN_TAB [24] = '{
    29'd377487360, 29'd222843801, 29'd117744544, 29'd59768969,
    29'd30000467,  29'd15014858,  29'd7509261,   29'd3754860,
    29'd1877459,   29'd938733,    29'd469367,    29'd234683,
    29'd117342,    29'd58671,     29'd29335,     29'd14668,
    29'd7334,      29'd3667,      29'd1833,      29'd917,
    29'd458,       29'd229,       29'd115,       29'd57
  };

  typedef enum logic {
    OP_TO_CART  = 1'b0,
    OP_TO_POLAR = 1'b1
  } op_t;

  // vector handed from cell to cell
  typedef struct packed {
    op_t               op;
    logic              origin;
    logic              base_on;
    logic              base_neg;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [Z_W-1:0]    z;
  } vec_t;

  // gain compensation for n micro-rotations, Q30
  function automatic logic [GAIN_W-1:0] gain_q30(input int n);
    longint sh;
    longint tail;
    sh   = longint'(2 * n);
    tail = (K_TAIL + (longint'(1) << (sh - 1))) >> sh;
    return GAIN_W'(K_BASE + tail);
  endfunction

endpackage

>>> design/polar_cartesian_converter.sv
// Polar/Cartesian converter: opcode 0 rotates (radius_in, 0) by angle_in and returns
// x_out/y_out; opcode 1 vectors (x_in, y_in) onto the x axis and returns radius_out and
// a full-quadrant angle_out in (-180,180]. Angles are in 1/128 degree. The datapath is an
// unrolled chain of CORDIC_STAGES micro-rotation cells between an input stage (angle
// folding and gain pre-scale) and two output stages (rounding, radius gain multiply,
// output register). One transfer is taken every cycle while the output is not stalled;
// each stage holds while its successor is full, so in_ready follows
// out_ready through the chain and bubbles are filled while a result waits.
module polar_cartesian_converter #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] x_in,
  input  logic [15:0] y_in,
  input  logic [15:0] radius_in,
  input  logic [15:0] angle_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [16:0] x_out,
  output logic [16:0] y_out,
  output logic [15:0] radius_out,
  output logic [15:0] angle_out
);

  localparam logic [pcc_pkg::GAIN_W-1:0] GAIN = pcc_pkg::gain_q30(CORDIC_STAGES);

  logic [CORDIC_STAGES:0] chain_valid;
  logic [CORDIC_STAGES:0] chain_ready;
  pcc_pkg::vec_t          chain_data [CORDIC_STAGES+1];

  // start vector
  pcc_front #(
    .GAIN(GAIN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .x_in      (x_in),
    .y_in      (y_in),
    .radius_in (radius_in),
    .angle_in  (angle_in),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // micro-rotation chain
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    pcc_cell #(
      .STAGE(i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // rounding, radius and output register
  pcc_back #(
    .GAIN(GAIN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (chain_valid[CORDIC_STAGES]),
    .in_ready   (chain_ready[CORDIC_STAGES]),
    .in_data    (chain_data[CORDIC_STAGES]),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .x_out      (x_out),
    .y_out      (y_out),
    .radius_out (radius_out),
    .angle_out  (angle_out)
  );

`ifndef SYNTHESIS
  a_mode_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (x_out != 17'h0 || y_out != 17'h0)) |-> (radius_out == 16'h0 && angle_out == 16'h0))
    else $error("cartesian and polar result fields both nonzero");
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ($signed(angle_out) > -16'sd23040 && $signed(angle_out) <= 16'sd23040))
    else $error("angle result outside half-open turn");
  a_xy_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (x_out != 17'h10000 && y_out != 17'h10000))
    else $error("cartesian result outside limit");
  a_ready_path: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side is ready");
`endif

endmodule

>>> design/pcc_front.sv
module pcc_front #(
  parameter logic [pcc_pkg::GAIN_W-1:0] GAIN = 30'd652039507
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                opcode,
  input  logic [15:0]         x_in,
  input  logic [15:0]         y_in,
  input  logic [15:0]         radius_in,
  input  logic [15:0]         angle_in,
  output logic                out_valid,
  input  logic                out_ready,
  output pcc_pkg::vec_t       out_data
);

  logic signed [16:0] ang;
  logic signed [16:0] ang_wrap;
  logic signed [16:0] ang_fold;
  logic               flip;
  logic [45:0]        prod;
  logic [45:0]        prod_rnd;
  logic [31:0]        mag;
  logic signed [16:0] xc;
  logic signed [16:0] yc;
  logic               x_neg;
  pcc_pkg::vec_t      vec_next;

  // bring polar angle into (-180,180], then fold into [-90,90]
  always_comb begin
    ang = $signed({angle_in[15], angle_in});
    ang_wrap = ang;
    if (ang > pcc_pkg::HALF_TURN) begin
      ang_wrap = ang - 17'(pcc_pkg::FULL_TURN);
    end else if (ang <= -pcc_pkg::HALF_TURN) begin
      ang_wrap = ang + 17'(pcc_pkg::FULL_TURN);
    end
    flip = 1'b0;
    ang_fold = ang_wrap;
    if (ang_wrap > pcc_pkg::QUARTER_TURN) begin
      flip = 1'b1;
      ang_fold = ang_wrap - 17'(pcc_pkg::HALF_TURN);
    end else if (ang_wrap < -pcc_pkg::QUARTER_TURN) begin
      flip = 1'b1;
      ang_fold = ang_wrap + 17'(pcc_pkg::HALF_TURN);
    end
  end

  // pre-scaled start radius
  assign prod     = 46'(radius_in) * 46'(GAIN);
  assign prod_rnd = prod + 46'd8192;
  assign mag      = prod_rnd[45:14];

  // mirror left half-plane vectors for vectoring
  assign x_neg = x_in[15];
  assign xc = x_neg ? -$signed({x_in[15], x_in}) : $signed({x_in[15], x_in});
  assign yc = x_neg ? -$signed({y_in[15], y_in}) : $signed({y_in[15], y_in});

  // start vector
  always_comb begin
    vec_next = '0;
    vec_next.op = pcc_pkg::op_t'(opcode);
    if (pcc_pkg::op_t'(opcode) == pcc_pkg::OP_TO_CART) begin
      vec_next.x = flip ? (pcc_pkg::DATA_W'(0) - {3'b000, mag}) : {3'b000, mag};
      vec_next.y = '0;
      vec_next.z = {ang_fold[15:0], 16'h0000};
    end else begin
      vec_next.origin   = (x_in == 16'h0000) && (y_in == 16'h0000);
      vec_next.base_on  = x_neg;
      vec_next.base_neg = y_in[15];
      vec_next.x = {{2{xc[16]}}, xc, 16'h0000};
      vec_next.y = {{2{yc[16]}}, yc, 16'h0000};
      vec_next.z = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= vec_next;
    end
  end

endmodule

>>> design/pcc_cell.sv
module pcc_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcc_pkg::vec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output pcc_pkg::vec_t out_data
);

  logic signed [pcc_pkg::DATA_W-1:0] xs;
  logic signed [pcc_pkg::DATA_W-1:0] ys;
  logic signed [pcc_pkg::DATA_W-1:0] dx;
  logic signed [pcc_pkg::DATA_W-1:0] dy;
  logic [pcc_pkg::Z_W-1:0]           step;
  logic                              rot_pos;
  pcc_pkg::vec_t                     vec_next;

  assign xs   = $signed(in_data.x);
  assign ys   = $signed(in_data.y);
  assign dx   = ys >>> STAGE;
  assign dy   = xs >>> STAGE;
  assign step = pcc_pkg::Z_W'(pcc_pkg::ATAN_TAB[STAGE]);

  // rotation toward zero angle or toward the x axis
  assign rot_pos = (in_data.op == pcc_pkg::OP_TO_POLAR) ? in_data.y[pcc_pkg::DATA_W-1]
                                                        : !in_data.z[pcc_pkg::Z_W-1];

  // one micro-rotation
  always_comb begin
    vec_next = in_data;
    if (rot_pos) begin
      vec_next.x = pcc_pkg::DATA_W'(xs - dx);
      vec_next.y = pcc_pkg::DATA_W'(ys + dy);
      vec_next.z = in_data.z - step;
    end else begin
      vec_next.x = pcc_pkg::DATA_W'(xs + dx);
      vec_next.y = pcc_pkg::DATA_W'(ys - dy);
      vec_next.z = in_data.z + step;
    end
  end

  assign in_ready = !out_valid || out_ready;

  // cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= vec_next;
    end
  end

endmodule

>>> design/pcc_back.sv
module pcc_back #(
  parameter logic [pcc_pkg::GAIN_W-1:0] GAIN = 30'd652039507
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  pcc_pkg::vec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [16:0]   x_out,
  output logic [16:0]   y_out,
  output logic [15:0]   radius_out,
  output logic [15:0]   angle_out
);

  localparam int PROD_W = 63;

  // round from guard bits and limit to +-65535
  function automatic logic [16:0] round_clamp(input logic [pcc_pkg::DATA_W-1:0] v);
    logic [pcc_pkg::DATA_W-1:0] s;
    logic signed [18:0]         r;
    logic [16:0]                res;
    s = v + pcc_pkg::DATA_W'(32768);
    r = $signed(s[pcc_pkg::DATA_W-1:pcc_pkg::GUARD]);
    if (r > 19'sd65535) begin
      res = 17'sd65535;
    end else if (r < -19'sd65535) begin
      res = -17'sd65535;
    end else begin
      res = r[16:0];
    end
    return res;
  endfunction

  logic                           valid_a;
  logic                           ready_a;
  pcc_pkg::op_t                   op_a;
  logic                           origin_a;
  logic [16:0]                    x_a;
  logic [16:0]                    y_a;
  logic [PROD_W-1:0]              prod_a;
  logic [15:0]                    ang_a;

  logic [32:0]                    xpos;
  logic [PROD_W-1:0]              prod_next;
  logic signed [32:0]             base;
  logic signed [32:0]             asum;
  logic signed [16:0]             ang_raw;
  logic signed [16:0]             ang_next;
  logic [PROD_W-1:0]              rsum;
  logic [16:0]                    rad_raw;
  logic [15:0]                    rad;

  // vector length times gain
  assign xpos      = in_data.x[pcc_pkg::DATA_W-1] ? 33'd0 : in_data.x[32:0];
  assign prod_next = PROD_W'(xpos) * PROD_W'(GAIN);

  // angle with half-turn offset, rounded and wrapped into (-180,180]
  always_comb begin
    base = 33'sd0;
    if (in_data.base_on) begin
      base = in_data.base_neg ? -33'(longint'(pcc_pkg::HALF_TURN) <<< pcc_pkg::GUARD)
                              :  33'(longint'(pcc_pkg::HALF_TURN) <<< pcc_pkg::GUARD);
    end
    asum = base + $signed({in_data.z[pcc_pkg::Z_W-1], in_data.z}) + 33'sd32768;
    ang_raw = asum[32:16];
    ang_next = ang_raw;
    if (ang_raw > pcc_pkg::HALF_TURN) begin
      ang_next = ang_raw - 17'(pcc_pkg::FULL_TURN);
    end else if (ang_raw <= -pcc_pkg::HALF_TURN) begin
      ang_next = ang_raw + 17'(pcc_pkg::FULL_TURN);
    end
  end

  assign in_ready = !valid_a || ready_a;

  // first stage: rounding and radius product
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
    end else if (in_ready) begin
      valid_a <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      op_a     <= in_data.op;
      origin_a <= in_data.origin;
      x_a      <= round_clamp(in_data.x);
      y_a      <= round_clamp(in_data.y);
      prod_a   <= prod_next;
      ang_a    <= ang_next[15:0];
    end
  end

  // radius rounding from Q46
  assign rsum    = prod_a + (PROD_W'(1) << 45);
  assign rad_raw = rsum[PROD_W-1:46];
  assign rad     = (rad_raw > 17'd65535) ? 16'hFFFF : rad_raw[15:0];

  assign ready_a = !out_valid || out_ready;

  // output register, unused fields cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_a) begin
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && valid_a) begin
      if (op_a == pcc_pkg::OP_TO_CART) begin
        x_out      <= x_a;
        y_out      <= y_a;
        radius_out <= '0;
        angle_out  <= '0;
      end else begin
        x_out      <= '0;
        y_out      <= '0;
        radius_out <= origin_a ? 16'h0000 : rad;
        angle_out  <= origin_a ? 16'h0000 : ang_a;
      end
    end
  end

endmodule
